/* rtl/sha256_stream_hasher_assert.svh */
// Assertion macros for the checker of the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ssh_pkg.sv */
// Package with the types, constants and helper functions of the SHA-256 stream hasher.
`default_nettype none

package ssh_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUNDS,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_byte;
    byte_sel_t byte_sel;
    logic      load_vars;
    logic      do_round;
    logic      add_chain;
    logic      emit_next;
    logic      reset_chain;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill_count;
    logic       round_last;
    logic       emit_last;
  } status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

/* rtl/ssh_datapath.sv */
// Datapath of the SHA-256 stream hasher: block register, schedule, round unit and chaining words.
`default_nettype none

module ssh_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ssh_pkg::cmd_t  cmd,
  input  wire logic [7:0]     data_byte,
  output ssh_pkg::status_t    status,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index
);
  import ssh_pkg::*;

  logic [511:0] msg;
  logic [31:0]  vars [8];
  logic [31:0]  chain [8];
  logic [5:0]   fill_count;
  logic [63:0]  length_bits;
  logic [5:0]   round;
  logic [2:0]   emit_idx;

  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0]  sum1, sum0, ch, maj, t1, t2;

  always_comb begin
    case (cmd.byte_sel)
      SEL_DATA: byte_in = data_byte;
      SEL_MARK: byte_in = PAD_MARK;
      SEL_LEN:  byte_in = length_bits[63:56];
      default:  byte_in = 8'h00;
    endcase
  end

  assign w0    = msg[511:480];
  assign w1    = msg[479:448];
  assign w9    = msg[223:192];
  assign w14   = msg[63:32];
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w0 + s0 + w9 + s1;

  assign sum1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
  assign ch   = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign t1   = vars[7] + sum1 + ch + ROUND_K[round] + w0;
  assign sum0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
  assign maj  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t2   = sum0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      msg <= {msg[503:0], byte_in};
    end else if (cmd.do_round) begin
      msg <= {msg[479:0], w_new};
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= chain[i];
      end
    end else if (cmd.do_round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INIT_HASH[i];
      end
      fill_count  <= '0;
      length_bits <= '0;
      round       <= '0;
      emit_idx    <= '0;
    end else begin
      if (cmd.shift_byte) begin
        fill_count <= fill_count + 6'd1;
        if (cmd.byte_sel == SEL_DATA) begin
          length_bits <= length_bits + BYTE_BITS;
        end else if (cmd.byte_sel == SEL_LEN) begin
          length_bits <= {length_bits[55:0], 8'h00};
        end
      end
      if (cmd.load_vars) begin
        round <= '0;
      end else if (cmd.do_round) begin
        round <= round + 6'd1;
      end
      if (cmd.reset_chain) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= INIT_HASH[i];
        end
      end else if (cmd.add_chain) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (cmd.emit_next) begin
        emit_idx <= emit_idx + 3'd1;
      end
    end
  end

  assign status.fill_count = fill_count;
  assign status.round_last = (round == LAST_ROUND);
  assign status.emit_last  = (emit_idx == LAST_WORD_IDX);
  assign digest_word       = chain[emit_idx];
  assign word_index        = emit_idx;

endmodule

`default_nettype wire

/* rtl/ssh_ctrl.sv */
// Controller state machine of the SHA-256 stream hasher.
`default_nettype none

module ssh_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             command,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire ssh_pkg::status_t status,
  output ssh_pkg::cmd_t         cmd
);
  import ssh_pkg::*;

  state_t state, state_next;
  logic   finishing, finishing_next;
  logic   mark_done, mark_done_next;
  logic   len_phase, len_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finishing <= 1'b0;
      mark_done <= 1'b0;
      len_phase <= 1'b0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      mark_done <= mark_done_next;
      len_phase <= len_phase_next;
    end
  end

  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    mark_done_next = mark_done;
    len_phase_next = len_phase;
    cmd            = '0;
    cmd.byte_sel   = SEL_DATA;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_ABSORB) begin
            cmd.shift_byte = 1'b1;
            if (status.fill_count == LAST_POS) begin
              cmd.load_vars = 1'b1;
              state_next    = ST_ROUNDS;
            end
          end else begin
            finishing_next = 1'b1;
            state_next     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.shift_byte = 1'b1;
        if (!mark_done) begin
          cmd.byte_sel   = SEL_MARK;
          mark_done_next = 1'b1;
        end else if (len_phase || status.fill_count == LEN_POS) begin
          cmd.byte_sel   = SEL_LEN;
          len_phase_next = 1'b1;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        if (status.fill_count == LAST_POS) begin
          cmd.load_vars = 1'b1;
          state_next    = ST_ROUNDS;
        end
      end
      ST_ROUNDS: begin
        cmd.do_round = 1'b1;
        if (status.round_last) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
        if (len_phase) begin
          state_next = ST_EMIT;
        end else if (finishing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          if (status.emit_last) begin
            cmd.reset_chain = 1'b1;
            finishing_next  = 1'b0;
            mark_done_next  = 1'b0;
            len_phase_next  = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher.
// The input channel (in_valid, in_ready) carries one request per byte: command selects
// absorb, which appends data_byte to the message, or finish, which closes the message.
// The output channel (out_valid, out_ready) carries the eight digest words of a finished
// message, word_index 0 first, with last_word set on the eighth word.
// An absorb request shifts its byte in as it is accepted. The request that completes a
// 64-byte block then runs 64 rounds in the shared round unit, one round per cycle, and
// then folds the round variables into the chaining words.
// A finish request shifts the padding bytes through the block register at one byte per
// cycle, 64 minus the pending byte count, plus 64 more when more than 55 bytes are
// pending, then compresses each padded block in the same way. The digest words follow, one
// per cycle while out_ready is high. The block takes one request at a time and holds
// in_ready low from acceptance of a completing or finishing request until its work ends.
// When the receiver stalls, the current word stays on the output unchanged.
// Reset loads the initial hash values and clears the byte count and the bit length.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  import ssh_pkg::*;

  cmd_t    cmd;
  status_t status;

  ssh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  assign last_word = status.emit_last;

endmodule

`default_nettype wire

/* rtl/ssh_checker.sv */
// Port-level checker of the SHA-256 stream hasher and its bind statement.
`default_nettype none
`include "sha256_stream_hasher_assert.svh"

module ssh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        command,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);
  import ssh_pkg::*;

  `SSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index), "Stalled digest word changed.")
  `SSH_ASSERT_SAME(a_busy_emit, out_valid, !in_ready, "Request taken while digest words are pending.")
  `SSH_ASSERT_SAME(a_last_flag, out_valid, last_word == (word_index == LAST_WORD_IDX), "Last flag does not match word index.")
  `SSH_ASSERT_NEXT(a_word_order, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1), "Digest words out of order.")
  `SSH_ASSERT_NEXT(a_finish_busy, in_valid && in_ready && command == CMD_FINISH, !in_ready, "Finish request did not start padding.")

endmodule

bind sha256_stream_hasher ssh_checker u_ssh_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .command     (command),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the SHA-256 stream hasher with a built-in digest model.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssh_pkg::*;

  typedef struct packed {
    logic         cmd;
    logic [7:0]   data;
    logic         known;
    logic [255:0] digest;
  } dir_row_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [255:0] DIGEST_EMPTY =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] DIGEST_ABC =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam int DIR_ROWS = 16;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_FINISH, 8'h00, 1'b1, DIGEST_EMPTY},
    '{CMD_ABSORB, 8'h61, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'h62, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'h63, 1'b0, 256'h0},
    '{CMD_FINISH, 8'hff, 1'b1, DIGEST_ABC},
    '{CMD_FINISH, 8'h5a, 1'b1, DIGEST_EMPTY},
    '{CMD_ABSORB, 8'h00, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'hff, 1'b0, 256'h0},
    '{CMD_FINISH, 8'h00, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'h80, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'h7f, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'h55, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'haa, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'h01, 1'b0, 256'h0},
    '{CMD_ABSORB, 8'hfe, 1'b0, 256'h0},
    '{CMD_FINISH, 8'ha5, 1'b0, 256'h0}
  };

  localparam int IDLE_PCT [4] = '{0, 70, 0, 30};
  localparam int STALL_PCT [4] = '{0, 0, 70, 30};
  localparam int EDGE_LEN [11] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  logic [31:0] hash_chain [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  byte_fill;
  logic [63:0] bit_len;

  digest_word_t digest_due [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int req_count = 0;
  int msg_count = 0;
  int words_checked = 0;
  int error_count = 0;

  sha256_stream_hasher u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void fold_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
  endfunction

  // Returns 1 when the request closes a message, with its digest in dig.
  function automatic logic hash_step(input logic c, input logic [7:0] b,
                                     output logic [255:0] dig);
    logic [63:0] len;
    int pos;
    dig = '0;
    if (c == CMD_ABSORB) begin
      block_bytes[byte_fill] = b;
      bit_len = bit_len + 64'd8;
      byte_fill = byte_fill + 6'd1;
      if (byte_fill == 6'd0) fold_block();
      return 1'b0;
    end
    len = bit_len;
    pos = byte_fill;
    block_bytes[pos] = PAD_MARK;
    pos = pos + 1;
    if (pos > LEN_POS) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos = pos + 1;
      end
      fold_block();
      pos = 0;
    end
    while (pos < LEN_POS) begin
      block_bytes[pos] = 8'h00;
      pos = pos + 1;
    end
    for (int k = 0; k < 8; k++) block_bytes[LEN_POS + k] = len[63 - 8*k -: 8];
    fold_block();
    for (int k = 0; k < 8; k++) dig[255 - 32*k -: 32] = hash_chain[k];
    hash_chain = INIT_HASH;
    byte_fill = 6'd0;
    bit_len = 64'd0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("tb: %s", what);
  endtask

  // Called just after a rising edge; returns just after the edge that accepts the request.
  task automatic push_req(input logic c, input logic [7:0] b, input logic known,
                          input logic [255:0] golden);
    logic [255:0] dig;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    data_byte <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    req_count++;
    if (hash_step(c, b, dig)) begin
      msg_count++;
      if (known) dig = golden;
      for (int k = 0; k < 8; k++) begin
        digest_due.push_back('{dig[255 - 32*k -: 32], 3'(k), (k == LAST_WORD_IDX)});
      end
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(negedge clk) begin
    digest_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (digest_due.size() == 0) begin
        flag_error($sformatf("unexpected digest word %h index %0d", digest_word, word_index));
      end else begin
        exp_w = digest_due.pop_front();
        if (digest_word !== exp_w.word || word_index !== exp_w.idx ||
            last_word !== exp_w.last) begin
          flag_error($sformatf("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                               exp_w.word, exp_w.idx, exp_w.last,
                               digest_word, word_index, last_word));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: timeout with %0d digest words outstanding", digest_due.size());
    $display("tb: errors");
    $finish;
  end

  initial begin
    int len;
    int phase_items;
    int phase_msgs;
    hash_chain = INIT_HASH;
    byte_fill = 6'd0;
    bit_len = 64'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      push_req(DIRECTED[r].cmd, DIRECTED[r].data, DIRECTED[r].known, DIRECTED[r].digest);
    end

    for (int p = 0; p < 4; p++) begin
      src_idle_pct = IDLE_PCT[p];
      sink_stall_pct <= STALL_PCT[p];
      phase_items = 0;
      phase_msgs = 0;
      while (phase_items < 50 || phase_msgs < 2) begin
        if ($urandom_range(99) < 40) len = EDGE_LEN[$urandom_range(10)];
        else len = $urandom_range(70);
        for (int i = 0; i < len; i++) push_req(CMD_ABSORB, 8'($urandom), 1'b0, 256'h0);
        push_req(CMD_FINISH, 8'($urandom), 1'b0, 256'h0);
        phase_items += len + 1;
        phase_msgs++;
      end
    end
    in_valid <= 1'b0;

    while (digest_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("tb: %0d requests in %0d messages, %0d digest words compared",
             req_count, msg_count, words_checked);
    $display("tb: idle and stall mixes run: none, sender, receiver, both; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
